// ----- src/hwmf_pkg.sv -----
// Shared types, constants and hash helpers for the hashed word mask filter.
package hwmf_pkg;

	localparam logic [31:0] HASH_INIT  = 32'hFFFF_FFFF;
	localparam logic [31:0] ROM_SEED   = 32'hD2A9_F7BD;
	localparam logic [31:0] ROM_MUL    = 32'h0808_8405;
	localparam logic [7:0]  SPACE_CHAR = 8'd32;
	localparam logic [7:0]  MASK_RESET = 8'd42;
	localparam logic [7:0]  UPPER_A    = 8'd65;
	localparam logic [7:0]  UPPER_Z    = 8'd90;
	localparam logic [7:0]  CASE_OFS   = 8'd32;

	localparam logic [1:0] ST_MSG   = 2'd0;
	localparam logic [1:0] ST_ADDED = 2'd1;
	localparam logic [1:0] ST_DUP   = 2'd2;
	localparam logic [1:0] ST_DROP  = 2'd3;

	typedef logic [31:0] rom_t [256];

	function automatic rom_t gen_rom();
		rom_t        r;
		logic [31:0] seed;
		seed = ROM_SEED;
		for (int i = 0; i < 256; i++) begin
			seed = seed * ROM_MUL + 32'd1;
			r[i] = seed;
		end
		return r;
	endfunction

	localparam rom_t HASH_ROM = gen_rom();

	function automatic logic [31:0] hash_byte(input logic [31:0] h, input logic [7:0] b);
		return ((h << 5) + h) ^ HASH_ROM[b];
	endfunction

	typedef struct packed {
		logic       mode;
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       was_masked;
		logic [1:0] status;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [2:0] {
		K_DICT_MID,
		K_DICT_END,
		K_SPACE,
		K_OVER_PASS,
		K_OVER_FLUSH,
		K_PLAIN_MID,
		K_PLAIN_END
	} kind_e;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic decode;
		logic rem_step;
		logic scan_rd;
		logic scan_cmp;
		logic insert;
		logic emit_stat;
		logic flush_rd;
		logic flush_emit;
		logic emit_tail;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic  clr_last;
		kind_e kind;
		logic  scan_skip;
		logic  rem_last;
		logic  way_last;
		logic  len_zero;
		logic  idx_last;
		logic  out_free;
	} sts_t;

endpackage

// ----- src/hwmf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module hwmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ----- src/hwmf_ctrl.sv -----
// Sequencer for the filter: clear pass, decode, set scan, flush and emit.
module hwmf_ctrl
	import hwmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [10:0] {
		S_CLEAR      = 11'b000_0000_0001,
		S_IDLE       = 11'b000_0000_0010,
		S_DECODE     = 11'b000_0000_0100,
		S_REM        = 11'b000_0000_1000,
		S_SCAN_RD    = 11'b000_0001_0000,
		S_SCAN_CMP   = 11'b000_0010_0000,
		S_INSERT     = 11'b000_0100_0000,
		S_EMIT_STAT  = 11'b000_1000_0000,
		S_FLUSH_RD   = 11'b001_0000_0000,
		S_FLUSH_EMIT = 11'b010_0000_0000,
		S_TAIL       = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   finish_d;
	logic   finish_q;

	// where to go once the set has been looked up (or skipped)
	function automatic state_t after_scan(input sts_t s, input logic done);
		state_t n;
		if (s.kind == K_DICT_END) begin
			n = done ? S_INSERT : S_EMIT_STAT;
		end else begin
			n = s.len_zero ? S_TAIL : S_FLUSH_RD;
		end
		return n;
	endfunction

	assign in_stall = (state_q != S_IDLE) || finish_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		finish_d = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && !finish_q) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				unique case (sts.kind)
					K_DICT_MID, K_PLAIN_MID: state_d = S_IDLE;
					K_OVER_PASS:             state_d = S_TAIL;
					K_OVER_FLUSH:            state_d = S_FLUSH_RD;
					default:                 state_d = S_REM;
				endcase
			end
			S_REM: begin
				if (sts.scan_skip) begin
					state_d = after_scan(sts, 1'b0);
				end else begin
					cmd.rem_step = 1'b1;
					if (sts.rem_last) state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d      = sts.way_last ? after_scan(sts, 1'b1) : S_SCAN_RD;
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = S_EMIT_STAT;
			end
			S_EMIT_STAT: begin
				if (sts.out_free) begin
					cmd.emit_stat = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_FLUSH_RD: begin
				cmd.flush_rd = 1'b1;
				state_d      = S_FLUSH_EMIT;
			end
			S_FLUSH_EMIT: begin
				if (sts.out_free) begin
					cmd.flush_emit = 1'b1;
					if (!sts.idx_last) begin
						state_d = S_FLUSH_RD;
					end else if (sts.kind == K_SPACE || sts.kind == K_OVER_FLUSH) begin
						state_d = S_TAIL;
					end else begin
						state_d  = S_IDLE;
						finish_d = 1'b1;
					end
				end
			end
			S_TAIL: begin
				if (sts.out_free) begin
					cmd.emit_tail = 1'b1;
					state_d       = S_IDLE;
					finish_d      = 1'b1;
				end
			end
			default: state_d = S_CLEAR;
		endcase
		cmd.finish = finish_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			finish_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			finish_q <= finish_d;
		end
	end
endmodule

// ----- src/hwmf_dp.sv -----
// Datapath: hash, word buffer, bucketed hash set, remainder unit, output register.
module hwmf_dp
	import hwmf_pkg::*;
#(
	parameter int BUCKETS  = 1024,
	parameter int WAYS     = 4,
	parameter int MAX_WORD = 63
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  logic      cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  cmd_t      cmd,
	output sts_t      sts,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	localparam int SET_DEPTH = BUCKETS * WAYS;
	localparam int AW = $clog2(SET_DEPTH);
	localparam int RW = $clog2(BUCKETS);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LW = $clog2(MAX_WORD + 1);
	localparam int BW = $clog2(MAX_WORD);
	// reciprocal of BUCKETS scaled so the quotient estimate is low by at most one
	localparam int BF = $clog2(BUCKETS + 1) - 1;
	localparam int SH = 31 + BF;
	localparam logic [31:0] RECIP = 32'((64'd1 << SH) / 64'(BUCKETS));

	in_item_t    item_q;
	kind_e       kind_q, kind_d;
	logic [31:0] hash_q, key_q, hash_new;
	logic [LW-1:0] len_q, idx_q;
	logic        ovl_q;
	logic [RW-1:0] rem_q;
	logic [1:0]  step_q;
	logic [31:0] quot_q, qb_q, diff_q;
	logic [63:0] recip_prod, qb_prod;
	logic [WW-1:0] way_q, empty_way_q;
	logic        dup_q, empty_q;
	logic [AW-1:0] clr_q, base, set_rd_addr, set_wr_addr;
	logic        set_wr_en;
	logic [31:0] set_wr_data, set_rd_data;
	logic [7:0]  buf_rd_data, lc, mask_q;
	logic        buf_wr_en;
	logic        out_valid_q, out_free;
	out_item_t   out_q;
	logic [1:0]  set_status;

	// classify the incoming request against current word state
	always_comb begin
		if (!in_item.mode) begin
			kind_d = in_item.end_of_text ? K_DICT_END : K_DICT_MID;
		end else if (in_item.text_byte == SPACE_CHAR) begin
			kind_d = K_SPACE;
		end else if (ovl_q) begin
			kind_d = K_OVER_PASS;
		end else if (len_q >= LW'(MAX_WORD)) begin
			kind_d = K_OVER_FLUSH;
		end else begin
			kind_d = in_item.end_of_text ? K_PLAIN_END : K_PLAIN_MID;
		end
	end

	assign lc = (item_q.text_byte >= UPPER_A && item_q.text_byte <= UPPER_Z)
		? item_q.text_byte + CASE_OFS : item_q.text_byte;
	assign hash_new = hash_byte(hash_q, item_q.mode ? lc : item_q.text_byte);

	assign recip_prod = 64'(key_q) * 64'(RECIP);
	assign qb_prod    = 64'(quot_q) * 64'(BUCKETS);
	assign base  = AW'(rem_q) * AW'(WAYS);

	assign set_wr_en   = cmd.clr_step || (cmd.insert && !dup_q && empty_q);
	assign set_wr_addr = cmd.clr_step ? clr_q : base + AW'(empty_way_q);
	assign set_wr_data = cmd.clr_step ? 32'd0 : key_q;
	assign set_rd_addr = base + AW'(way_q);

	assign buf_wr_en = cmd.decode && (kind_q == K_PLAIN_MID || kind_q == K_PLAIN_END);

	hwmf_ram #(.WIDTH(32), .DEPTH(SET_DEPTH)) u_set (
		.clk     (clk),
		.wr_en   (set_wr_en),
		.wr_addr (set_wr_addr),
		.wr_data (set_wr_data),
		.rd_en   (cmd.scan_rd),
		.rd_addr (set_rd_addr),
		.rd_data (set_rd_data)
	);

	hwmf_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_buf (
		.clk     (clk),
		.wr_en   (buf_wr_en),
		.wr_addr (len_q[BW-1:0]),
		.wr_data (item_q.text_byte),
		.rd_en   (cmd.flush_rd),
		.rd_addr (idx_q[BW-1:0]),
		.rd_data (buf_rd_data)
	);

	assign set_status = dup_q ? ST_DUP : (empty_q ? ST_ADDED : ST_DROP);
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		sts.clr_last  = (clr_q == AW'(SET_DEPTH - 1));
		sts.kind      = kind_q;
		sts.scan_skip = (key_q == 32'd0)
			|| (kind_q == K_SPACE && (ovl_q || len_q == '0));
		sts.rem_last  = (step_q == 2'd3);
		sts.way_last  = (way_q == WW'(WAYS - 1));
		sts.len_zero  = (len_q == '0);
		sts.idx_last  = (idx_q + LW'(1) == len_q);
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= HASH_INIT;
			len_q       <= '0;
			ovl_q       <= 1'b0;
			clr_q       <= '0;
			mask_q      <= MASK_RESET;
			out_valid_q <= 1'b0;
			kind_q      <= K_DICT_MID;
		end else begin
			if (cfg_wr_en) mask_q <= cfg_wr_data;
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.accept) kind_q <= kind_d;

			if (cmd.decode) begin
				unique case (kind_q)
					K_DICT_MID, K_PLAIN_MID: hash_q <= hash_new;
					K_DICT_END:              hash_q <= HASH_INIT;
					default:                 hash_q <= hash_q;
				endcase
				if (kind_q == K_PLAIN_MID || kind_q == K_PLAIN_END) len_q <= len_q + LW'(1);
			end

			if (cmd.finish) begin
				unique case (kind_q)
					K_OVER_PASS: begin
						if (item_q.end_of_text) begin
							ovl_q  <= 1'b0;
							hash_q <= HASH_INIT;
						end
					end
					K_OVER_FLUSH: begin
						len_q  <= '0;
						hash_q <= HASH_INIT;
						ovl_q  <= !item_q.end_of_text;
					end
					K_SPACE: begin
						len_q  <= '0;
						hash_q <= HASH_INIT;
						ovl_q  <= 1'b0;
					end
					default: begin
						len_q  <= '0;
						hash_q <= HASH_INIT;
					end
				endcase
			end

			if (cmd.emit_stat || cmd.flush_emit || cmd.emit_tail) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= in_item;
		if (cmd.decode) begin
			dup_q   <= 1'b0;
			empty_q <= 1'b0;
			idx_q   <= '0;
			rem_q   <= '0;
			step_q  <= '0;
			way_q   <= '0;
			unique case (kind_q)
				K_DICT_END, K_PLAIN_END: key_q <= hash_new;
				default:                 key_q <= hash_q;
			endcase
		end
		// four-stage bucket index: key is held, so the chain settles after four steps
		if (cmd.rem_step) begin
			quot_q <= 32'(recip_prod >> SH);
			qb_q   <= qb_prod[31:0];
			diff_q <= key_q - qb_q;
			rem_q  <= (diff_q >= 32'(BUCKETS)) ? RW'(diff_q - 32'(BUCKETS)) : RW'(diff_q);
			step_q <= step_q + 2'd1;
		end
		if (cmd.scan_cmp) begin
			if (set_rd_data == key_q) dup_q <= 1'b1;
			if (set_rd_data == 32'd0 && !empty_q) begin
				empty_q     <= 1'b1;
				empty_way_q <= way_q;
			end
			way_q <= way_q + WW'(1);
		end
		if (cmd.flush_emit) idx_q <= idx_q + LW'(1);

		if (cmd.emit_stat) begin
			out_q <= '{out_byte: 8'd0, was_masked: 1'b0, status: set_status, last_of_run: 1'b1};
		end else if (cmd.flush_emit) begin
			out_q <= '{out_byte: dup_q ? mask_q : buf_rd_data, was_masked: dup_q,
				status: ST_MSG, last_of_run: sts.idx_last && kind_q == K_PLAIN_END};
		end else if (cmd.emit_tail) begin
			out_q <= '{out_byte: item_q.text_byte, was_masked: 1'b0, status: ST_MSG,
				last_of_run: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
endmodule

// ----- src/hashed_word_mask_filter_top.sv -----
// Top level of the hashed word mask filter.
// Takes one request at a time. After reset the hash set is cleared, one entry per cycle,
// all BUCKETS*WAYS entries (4096 by default), while input is stalled. A dictionary or
// message byte that only extends a word passes through accept and decode. A word end finds
// the bucket by reciprocal multiplication (skipped when the hash is zero or there is no
// word to look up), then reads the bucket ways one at a time (a read and a compare state
// per way), and a dictionary word then inserts and reports its status. Each flushed word
// byte passes through the buffer memory's registered read port before it is emitted, a
// trailing space or byte is emitted after the word, and a message run ends with a finish
// step that closes the word. Output stalls hold the sequencer in its emit states. Results
// leave through an output register, so a stalled result does not hold back the next read of the buffer.
module hashed_word_mask_filter_top
	import hwmf_pkg::*;
#(
	parameter int BUCKETS  = 1024,
	parameter int WAYS     = 4,
	parameter int MAX_WORD = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);
	cmd_t cmd;
	sts_t sts;

	hwmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	hwmf_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS), .MAX_WORD(MAX_WORD)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_item     (in_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the hashed word mask filter top level.
module testbench;
	import hwmf_pkg::*;

	localparam int N_BUCKETS  = 1024;
	localparam int N_WAYS     = 4;
	localparam int WORD_MAX   = 63;
	localparam int IDLE_LIMIT = 40000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_item = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_item;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = '0;

	hashed_word_mask_filter_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// filter state as predicted
	logic [31:0] char_code [256];
	logic [31:0] word_hash;
	logic [7:0]  held_bytes [WORD_MAX];
	int          held_len;
	logic        passing_long;
	logic [31:0] known_hash [N_BUCKETS*N_WAYS];
	logic [7:0]  mask_byte;
	out_item_t   expected_out [$];

	int send_idle_pct;
	int stall_pct;
	int errors;
	int idle_cycles;
	int sent_count;

	logic [7:0] lex_word [16][8];
	int         lex_len [16];

	function automatic logic [31:0] mix_char(logic [31:0] h, logic [7:0] b);
		return ((h << 5) + h) ^ char_code[b];
	endfunction

	function automatic logic word_known(logic [31:0] h);
		int base;
		base = (h % N_BUCKETS) * N_WAYS;
		if (h == 32'd0) return 1'b0;
		for (int w = 0; w < N_WAYS; w++)
			if (known_hash[base + w] == h) return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [1:0] store_word(logic [31:0] h);
		int base;
		base = (h % N_BUCKETS) * N_WAYS;
		if (h == 32'd0) return ST_DROP;
		for (int w = 0; w < N_WAYS; w++)
			if (known_hash[base + w] == h) return ST_DUP;
		for (int w = 0; w < N_WAYS; w++)
			if (known_hash[base + w] == 32'd0) begin
				known_hash[base + w] = h;
				return ST_ADDED;
			end
		return ST_DROP;
	endfunction

	function automatic void push_out(logic [7:0] b, logic m, logic [1:0] st);
		out_item_t r;
		r.out_byte = b;
		r.was_masked = m;
		r.status = st;
		r.last_of_run = 1'b0;
		expected_out.push_back(r);
	endfunction

	function automatic void flush_held(logic check);
		logic hit;
		hit = check && held_len > 0 && word_known(word_hash);
		for (int i = 0; i < held_len; i++)
			push_out(hit ? mask_byte : held_bytes[i], hit, ST_MSG);
		held_len = 0;
		word_hash = HASH_INIT;
	endfunction

	function automatic void predict_filter(in_item_t it);
		int        before_n;
		logic [7:0] lc;
		out_item_t r;
		before_n = expected_out.size();
		if (!it.mode) begin
			word_hash = mix_char(word_hash, it.text_byte);
			if (it.end_of_text) begin
				r.status = store_word(word_hash);
				word_hash = HASH_INIT;
				push_out(8'd0, 1'b0, r.status);
			end
		end else if (it.text_byte == SPACE_CHAR) begin
			flush_held(!passing_long);
			passing_long = 1'b0;
			push_out(it.text_byte, 1'b0, ST_MSG);
		end else if (passing_long) begin
			push_out(it.text_byte, 1'b0, ST_MSG);
			if (it.end_of_text) begin
				passing_long = 1'b0;
				word_hash = HASH_INIT;
			end
		end else if (held_len >= WORD_MAX) begin
			flush_held(1'b0);
			push_out(it.text_byte, 1'b0, ST_MSG);
			passing_long = !it.end_of_text;
		end else begin
			lc = (it.text_byte >= UPPER_A && it.text_byte <= UPPER_Z) ?
				it.text_byte + CASE_OFS : it.text_byte;
			held_bytes[held_len] = it.text_byte;
			held_len++;
			word_hash = mix_char(word_hash, lc);
			if (it.end_of_text) flush_held(1'b1);
		end
		if (expected_out.size() > before_n) begin
			r = expected_out.pop_back();
			r.last_of_run = 1'b1;
			expected_out.push_back(r);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_out.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result byte=%0d masked=%0d status=%0d last=%0d",
						out_item.out_byte, out_item.was_masked, out_item.status,
						out_item.last_of_run);
			end else begin
				out_item_t e;
				e = expected_out.pop_front();
				if (e.out_byte !== out_item.out_byte || e.was_masked !== out_item.was_masked ||
					e.status !== out_item.status || e.last_of_run !== out_item.last_of_run) begin
					errors++;
					if (errors <= 10)
						$display("exp byte=%0d masked=%0d status=%0d last=%0d, got %0d %0d %0d %0d",
							e.out_byte, e.was_masked, e.status, e.last_of_run,
							out_item.out_byte, out_item.was_masked, out_item.status,
							out_item.last_of_run);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("hashed_word_mask_filter_top: mismatch");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	task automatic send_request(logic mode, logic [7:0] b, logic eot);
		in_item_t it;
		it.mode = mode;
		it.text_byte = b;
		it.end_of_text = eot;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		predict_filter(it);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_text(logic mode, string s, logic eot);
		for (int i = 0; i < s.len(); i++)
			send_request(mode, s[i], eot && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_out.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_mask(logic [7:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mask_byte = v;
	endtask

	task automatic test_dictionary();
		send_text(1'b0, "cat", 1'b1);
		send_text(1'b0, "cat", 1'b1);
		send_request(1'b0, 8'h00, 1'b1);
		send_request(1'b0, 8'hFF, 1'b1);
	endtask

	task automatic test_masking();
		send_text(1'b1, " CaT dog", 1'b0);
		send_request(1'b1, SPACE_CHAR, 1'b0);
		send_text(1'b1, "cat", 1'b1);
		send_request(1'b1, 8'h00, 1'b0);
		send_request(1'b0, "x", 1'b0);     // mixed modes share one hash
		send_request(1'b1, 8'hFF, 1'b1);
		send_request(1'b1, SPACE_CHAR, 1'b1);
	endtask

	task automatic send_message_word(int k);
		logic [7:0] c;
		int n;
		if (k < 0) begin
			n = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				c = 8'($urandom_range(255));
				if (c == SPACE_CHAR) c = 8'h61;
				send_request(1'b1, c, $urandom_range(9) == 0);
			end
		end else
			for (int i = 0; i < lex_len[k]; i++) begin
				c = lex_word[k][i];
				if ($urandom_range(1)) c = c - CASE_OFS;
				send_request(1'b1, c, 1'b0);
			end
		send_request(1'b1, SPACE_CHAR, $urandom_range(4) == 0);
	endtask

	task automatic test_random(int items);
		int start_n;
		start_n = sent_count;
		while (sent_count - start_n < items) begin
			case ($urandom_range(9))
				0: begin
					int k;
					k = $urandom_range(15);
					for (int i = 0; i < lex_len[k]; i++)
						send_request(1'b0, lex_word[k][i], i == lex_len[k] - 1);
				end
				1: begin
					send_request(1'($urandom_range(1)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
				end
				default: begin
					send_message_word($urandom_range(2) == 0 ? -1 : $urandom_range(15));
				end
			endcase
		end
		send_request(1'b1, SPACE_CHAR, 1'b1);
	endtask

	initial begin
		logic [31:0] seed;
		seed = 32'hD2A9_F7BD;
		for (int i = 0; i < 256; i++) begin
			seed = seed * 32'h0808_8405 + 32'd1;
			char_code[i] = seed;
		end
		word_hash = HASH_INIT;
		held_len = 0;
		passing_long = 1'b0;
		foreach (known_hash[i]) known_hash[i] = '0;
		mask_byte = MASK_RESET;
		errors = 0;
		idle_cycles = 0;
		sent_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		for (int k = 0; k < 16; k++) begin
			lex_len[k] = $urandom_range(1, 8);
			for (int i = 0; i < 8; i++) lex_word[k][i] = 8'($urandom_range(8'h61, 8'h7A));
		end
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_dictionary();
		test_masking();
		write_mask(8'h00);
		test_masking();
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = (p == 1 || p == 3) ? ((p == 3) ? 7 : 72) : 0;
			stall_pct = (p == 2) ? 72 : ((p == 3) ? 7 : 0);
			test_random(80);
			write_mask(p == 0 ? 8'hFF : 8'($urandom_range(255)));
		end
		wait_drained();

		if (errors == 0)
			$display("hashed_word_mask_filter_top: match");
		else
			$display("hashed_word_mask_filter_top: mismatch");
		$finish;
	end

endmodule
